@@ hdl/edfq_pkg.sv @@
// ----------------------------------------------------------------------------
// edfq_pkg
// Types, codes and sizes shared by the deadline sorted ready queue modules.
// ----------------------------------------------------------------------------
package edfq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_POP     = 2'd1;
	localparam logic [1:0] OP_INS_POP = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  task_id;
		logic        task_kind;
		logic [31:0] released_at;
		logic [31:0] deadline;
	} req_t;

	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_task_id;
		logic        out_kind;
		logic [31:0] out_release_time;
		logic [31:0] out_deadline;
		logic [1:0]  status;
		logic [4:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  id;
		logic        kind;
		logic [31:0] rel;
		logic [31:0] dl;
	} entry_t;

	typedef struct packed {
		logic       insert;
		logic       pop;
		logic       load;
		logic [1:0] stat;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

endpackage

@@ hdl/edfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// edfq_ctrl
// Sequencer: takes an item, inserts on acceptance if asked and not full, then
// pops if asked and not empty and loads the result register once it is free.
// ----------------------------------------------------------------------------
module edfq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         operation,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  edfq_pkg::dp_stat_t dp_stat,
	output edfq_pkg::cmd_t     cmd
);

	edfq_pkg::state_t state_q, state_d;
	logic [1:0] op_q;
	logic       drop_q;
	logic       rsp_valid_q;
	logic       accept;
	logic       ins;
	logic       popish;
	logic       slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edfq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= edfq_pkg::OP_INSERT;
			drop_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				op_q   <= operation;
				drop_q <= ins && dp_stat.full;
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.insert = 1'b0;
		cmd.pop    = 1'b0;
		cmd.load   = 1'b0;
		ins        = (operation inside {edfq_pkg::OP_INSERT, edfq_pkg::OP_INS_POP});
		popish     = (op_q inside {edfq_pkg::OP_POP, edfq_pkg::OP_INS_POP});
		slot_free  = !rsp_valid_q || rsp_ready;
		accept     = 1'b0;
		if (drop_q) begin
			cmd.stat = edfq_pkg::STAT_FULL;
		end else if (popish && dp_stat.empty) begin
			cmd.stat = edfq_pkg::STAT_EMPTY;
		end else begin
			cmd.stat = edfq_pkg::STAT_OK;
		end
		case (state_q)
			edfq_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				accept     = req_valid;
				cmd.insert = req_valid && ins && !dp_stat.full;
				if (req_valid) begin
					state_d = edfq_pkg::S_POP;
				end
			end
			edfq_pkg::S_POP: begin
				if (slot_free) begin
					cmd.load = 1'b1;
					cmd.pop  = popish && !dp_stat.empty;
					state_d  = edfq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = edfq_pkg::S_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ hdl/edfq_datapath.sv @@
// ----------------------------------------------------------------------------
// edfq_datapath
// Shift-register queue of entries sorted by deadline, with every cell
// comparing against the new deadline in parallel, plus the result register.
// ----------------------------------------------------------------------------
module edfq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  edfq_pkg::req_t     req,
	input  edfq_pkg::cmd_t     cmd,
	output edfq_pkg::dp_stat_t dp_stat,
	output edfq_pkg::rsp_t     rsp
);

	edfq_pkg::entry_t cell_q [edfq_pkg::QUEUE_DEPTH];
	edfq_pkg::entry_t new_entry;
	edfq_pkg::rsp_t   rsp_q;
	logic [edfq_pkg::CNT_W-1:0] count_q;
	logic [edfq_pkg::CNT_W-1:0] count_next;
	logic [edfq_pkg::QUEUE_DEPTH-1:0] lt;

	assign new_entry.id   = req.task_id;
	assign new_entry.kind = req.task_kind;
	assign new_entry.rel  = req.released_at;
	assign new_entry.dl   = req.deadline;

	// cells ahead of the new entry
	always_comb begin
		for (int i = 0; i < edfq_pkg::QUEUE_DEPTH; i++) begin
			lt[i] = (edfq_pkg::CNT_W'(i) < count_q) && (cell_q[i].dl < req.deadline);
		end
	end

	assign dp_stat.full  = (count_q == edfq_pkg::CNT_W'(edfq_pkg::QUEUE_DEPTH));
	assign dp_stat.empty = (count_q == '0);

	always_comb begin
		count_next = count_q;
		if (cmd.insert) begin
			count_next = count_q + 1'b1;
		end else if (cmd.pop) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (!lt[0]) begin
				cell_q[0] <= new_entry;
			end
			for (int i = 1; i < edfq_pkg::QUEUE_DEPTH; i++) begin
				if (!lt[i]) begin
					if (lt[i-1]) begin
						cell_q[i] <= new_entry;
					end else begin
						cell_q[i] <= cell_q[i-1];
					end
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < edfq_pkg::QUEUE_DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.out_valid        <= cmd.pop;
			rsp_q.out_task_id      <= cmd.pop ? cell_q[0].id : '0;
			rsp_q.out_kind         <= cmd.pop ? cell_q[0].kind : 1'b0;
			rsp_q.out_release_time <= cmd.pop ? cell_q[0].rel : '0;
			rsp_q.out_deadline     <= cmd.pop ? cell_q[0].dl : '0;
			rsp_q.status           <= cmd.stat;
			rsp_q.occupancy        <= 5'(count_next);
		end
	end

	assign rsp = rsp_q;

endmodule

@@ hdl/deadline_sorted_ready_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_sorted_ready_queue
// Earliest-deadline-first ready queue with insert, pop and insert-then-pop.
// ----------------------------------------------------------------------------
// the item is accepted in idle, then the pop step loads the result register
// sequencer: takes no new item until the result of the last one is loaded
//   (insert at acceptance, then pop and result load in the pop state)
// a result not yet taken holds the pop step until the result register frees
// reset: entry count cleared at once, queue empty, no clearing pass
module deadline_sorted_ready_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  edfq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output edfq_pkg::rsp_t rsp
);

	edfq_pkg::cmd_t     cmd;
	edfq_pkg::dp_stat_t dp_stat;

	edfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.operation (req.operation),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	edfq_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cmd     (cmd),
		.dp_stat (dp_stat),
		.rsp     (rsp)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("item accepted while another in progress");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.out_valid) |-> (rsp.status != edfq_pkg::STAT_EMPTY))
		else $error("popped item flagged as empty pop");

	a_empty_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == edfq_pkg::STAT_EMPTY)
		|-> (rsp.occupancy == 5'd0 && !rsp.out_valid))
		else $error("empty pop with entries or popped item");

	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == edfq_pkg::STAT_FULL)
		|-> (rsp.occupancy == (rsp.out_valid ? 5'(edfq_pkg::QUEUE_DEPTH - 1)
			: 5'(edfq_pkg::QUEUE_DEPTH))))
		else $error("dropped insert without full queue");

endmodule
